// ===== sv/lfk_pkg.sv =====
// Shared types, constants and small functions for the leg forward kinematics block.
package lfk_pkg;

   localparam int IN_W       = 17;
   localparam int OUT_W      = 17;
   localparam int LEN_W      = 10;
   localparam int OFF_W      = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_BODY_PIVOT_RADIUS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIP_LENGTH        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_LENGTH      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_LENGTH      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HIP_HEIGHT        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ANKLE_OFFSET      = 3'd5;

   // Trig values are Q30, CORDIC angles are degrees Q16.
   localparam int TW = 32;
   localparam int ZW = 25;
   localparam logic signed [TW-1:0] CORDIC_GAIN = 32'sd652032874;

   // Reciprocal of 90 for the quadrant split: ceil(2^24 / 90).
   localparam int RECIP_W     = 18;
   localparam int RECIP_SHIFT = 24;
   localparam logic [RECIP_W-1:0] RECIP = 18'd186414;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   typedef struct packed {
      logic signed [TW-1:0] cos_v;
      logic signed [TW-1:0] sin_v;
   } trig_type;

   typedef struct packed {
      logic        [LEN_W-1:0] radius;
      logic        [LEN_W-1:0] hip_length;
      logic        [LEN_W-1:0] upper_length;
      logic        [LEN_W-1:0] lower_length;
      logic signed [LEN_W-1:0] hip_height;
   } geom_type;

   function automatic logic signed [ZW-1:0] atan_q16(input int idx);
      logic signed [ZW-1:0] r;
      case (idx)
         0:  r = 25'sd2949120;
         1:  r = 25'sd1740967;
         2:  r = 25'sd919879;
         3:  r = 25'sd466945;
         4:  r = 25'sd234379;
         5:  r = 25'sd117304;
         6:  r = 25'sd58666;
         7:  r = 25'sd29335;
         8:  r = 25'sd14668;
         9:  r = 25'sd7334;
         10: r = 25'sd3667;
         11: r = 25'sd1833;
         12: r = 25'sd917;
         13: r = 25'sd458;
         14: r = 25'sd229;
         15: r = 25'sd115;
         16: r = 25'sd57;
         17: r = 25'sd29;
         18: r = 25'sd14;
         19: r = 25'sd7;
         20: r = 25'sd4;
         21: r = 25'sd2;
         22: r = 25'sd1;
         default: r = 25'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [23:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > 24'sd65535) begin
         r = 17'sd65535;
      end else if (v < -24'sd65536) begin
         r = -17'sd65536;
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== sv/lfk_angle_reduce.sv =====
// Two-stage reduction of an angle into a quadrant and a residue in degrees Q16.
module lfk_angle_reduce #(
   parameter int ANGLE_FRAC_BITS = 7,
   parameter int SUM_W = 19
) (
   input  logic                            clock,
   input  logic                            advance,
   input  logic signed [SUM_W-1:0]         angle,
   output logic [1:0]                      quadrant,
   output logic signed [lfk_pkg::ZW-1:0]   residue
);

   localparam int UW    = SUM_W - ANGLE_FRAC_BITS;
   localparam int PW    = UW + lfk_pkg::RECIP_W + 1;
   localparam int QW    = PW - lfk_pkg::RECIP_SHIFT;
   localparam int RW    = SUM_W + 1;
   localparam int RES_W = ANGLE_FRAC_BITS + 7;
   localparam logic signed [RW-1:0] QUARTER = RW'(90 << ANGLE_FRAC_BITS);

   logic signed [PW-1:0]    prod_ff;
   logic signed [SUM_W-1:0] angle_ff;
   logic [1:0]              quad_ff;
   logic signed [lfk_pkg::ZW-1:0] res_ff;

   logic signed [UW-1:0] whole_deg;
   logic signed [QW-1:0] q0, q1;
   logic signed [RW-1:0] r0, r1;

   assign whole_deg = angle[SUM_W-1:ANGLE_FRAC_BITS];

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff  <= PW'(whole_deg) * $signed({1'b0, lfk_pkg::RECIP});
         angle_ff <= angle;
      end
   end

   // The reciprocal estimate is off by at most one quarter turn either way.
   always_comb begin
      q0 = prod_ff[PW-1:lfk_pkg::RECIP_SHIFT];
      r0 = RW'(angle_ff) - RW'(q0) * QUARTER;
      if (r0 < 0) begin
         q1 = q0 - QW'(1);
         r1 = r0 + QUARTER;
      end else if (r0 >= QUARTER) begin
         q1 = q0 + QW'(1);
         r1 = r0 - QUARTER;
      end else begin
         q1 = q0;
         r1 = r0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quad_ff <= q1[1:0];
         res_ff  <= lfk_pkg::ZW'({r1[RES_W-1:0], {(16 - ANGLE_FRAC_BITS){1'b0}}});
      end
   end

   assign quadrant = quad_ff;
   assign residue  = res_ff;

endmodule

// ===== sv/lfk_cordic.sv =====
// Pipelined rotation-mode CORDIC, one iteration per stage, with quadrant unfolding.
module lfk_cordic #(
   parameter int STAGES = 16
) (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [1:0]                    quadrant,
   input  logic signed [lfk_pkg::ZW-1:0] angle,
   output lfk_pkg::trig_type             result
);

   localparam int TW = lfk_pkg::TW;
   localparam int ZW = lfk_pkg::ZW;

   logic signed [TW-1:0] x_ff [STAGES];
   logic signed [TW-1:0] y_ff [STAGES];
   logic signed [ZW-1:0] z_ff [STAGES];
   logic [1:0]           q_ff [STAGES];
   lfk_pkg::trig_type    result_ff;

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic signed [TW-1:0] xp, yp;
      logic signed [ZW-1:0] zp;
      logic [1:0]           qp;

      if (i == 0) begin : g_first
         assign xp = lfk_pkg::CORDIC_GAIN;
         assign yp = '0;
         assign zp = angle;
         assign qp = quadrant;
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
         assign qp = q_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            q_ff[i] <= qp;
            if (!zp[ZW-1]) begin
               x_ff[i] <= xp - (yp >>> i);
               y_ff[i] <= yp + (xp >>> i);
               z_ff[i] <= zp - lfk_pkg::atan_q16(i);
            end else begin
               x_ff[i] <= xp + (yp >>> i);
               y_ff[i] <= yp - (xp >>> i);
               z_ff[i] <= zp + lfk_pkg::atan_q16(i);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         case (q_ff[STAGES-1])
            lfk_pkg::QUAD_0: begin
               result_ff.cos_v <= x_ff[STAGES-1];
               result_ff.sin_v <= y_ff[STAGES-1];
            end
            lfk_pkg::QUAD_1: begin
               result_ff.cos_v <= -y_ff[STAGES-1];
               result_ff.sin_v <= x_ff[STAGES-1];
            end
            lfk_pkg::QUAD_2: begin
               result_ff.cos_v <= -x_ff[STAGES-1];
               result_ff.sin_v <= -y_ff[STAGES-1];
            end
            default: begin
               result_ff.cos_v <= y_ff[STAGES-1];
               result_ff.sin_v <= -x_ff[STAGES-1];
            end
         endcase
      end
   end

   assign result = result_ff;

endmodule

// ===== sv/lfk_arm.sv =====
// Four-stage leg geometry: segment products, reach rounding, heading products, saturation.
module lfk_arm (
   input  logic                              clock,
   input  logic                              advance,
   input  lfk_pkg::geom_type                 geom,
   input  lfk_pkg::trig_type                 mount,
   input  lfk_pkg::trig_type                 heading,
   input  lfk_pkg::trig_type                 knee,
   input  lfk_pkg::trig_type                 ankle,
   output logic signed [lfk_pkg::OUT_W-1:0]  foot_x,
   output logic signed [lfk_pkg::OUT_W-1:0]  foot_y,
   output logic signed [lfk_pkg::OUT_W-1:0]  foot_z
);

   localparam int TW   = lfk_pkg::TW;
   localparam int PRW  = TW + 11;
   localparam int SW   = 45;
   localparam int R16W = SW - 14;
   localparam int HW   = R16W + TW;
   localparam int XW   = 62;

   // Stage A
   logic signed [PRW-1:0] uk_ff, la_ff, us_ff, ls_ff;
   lfk_pkg::trig_type     mount_a_ff, head_a_ff;
   // Stage B
   logic signed [R16W-1:0] reach16_ff;
   logic signed [SW-1:0]   z30_ff;
   lfk_pkg::trig_type      mount_b_ff, head_b_ff;
   // Stage C
   logic signed [PRW-1:0] xr_ff, yr_ff;
   logic signed [HW-1:0]  xh_ff, yh_ff;
   logic signed [lfk_pkg::OUT_W-1:0] z_c_ff;
   // Stage D
   logic signed [lfk_pkg::OUT_W-1:0] x_ff, y_ff, z_ff;

   logic signed [SW-1:0] reach30, z30;
   logic signed [XW-1:0] x46, y46;

   always_ff @(posedge clock) begin
      if (advance) begin
         uk_ff      <= PRW'($signed({1'b0, geom.upper_length})) * PRW'(knee.cos_v);
         la_ff      <= PRW'($signed({1'b0, geom.lower_length})) * PRW'(ankle.cos_v);
         us_ff      <= PRW'($signed({1'b0, geom.upper_length})) * PRW'(knee.sin_v);
         ls_ff      <= PRW'($signed({1'b0, geom.lower_length})) * PRW'(ankle.sin_v);
         mount_a_ff <= mount;
         head_a_ff  <= heading;
      end
   end

   assign reach30 = (SW'($signed({1'b0, geom.hip_length})) <<< 30) + SW'(uk_ff) + SW'(la_ff);
   assign z30     = (SW'(geom.hip_height) <<< 30) + SW'(us_ff) + SW'(ls_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         reach16_ff <= R16W'((reach30 + (SW'(1) <<< 13)) >>> 14);
         z30_ff     <= z30;
         mount_b_ff <= mount_a_ff;
         head_b_ff  <= head_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         xr_ff  <= PRW'($signed({1'b0, geom.radius})) * PRW'(mount_b_ff.cos_v);
         yr_ff  <= PRW'($signed({1'b0, geom.radius})) * PRW'(mount_b_ff.sin_v);
         xh_ff  <= HW'(reach16_ff) * HW'(head_b_ff.cos_v);
         yh_ff  <= HW'(reach16_ff) * HW'(head_b_ff.sin_v);
         z_c_ff <= lfk_pkg::sat_out(24'((z30_ff + (SW'(1) <<< 25)) >>> 26));
      end
   end

   assign x46 = (XW'(xr_ff) <<< 16) + XW'(xh_ff);
   assign y46 = (XW'(yr_ff) <<< 16) + XW'(yh_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff <= lfk_pkg::sat_out(24'((x46 + (XW'(1) <<< 41)) >>> 42));
         y_ff <= lfk_pkg::sat_out(24'((y46 + (XW'(1) <<< 41)) >>> 42));
         z_ff <= z_c_ff;
      end
   end

   assign foot_x = x_ff;
   assign foot_y = y_ff;
   assign foot_z = z_ff;

endmodule

// ===== sv/leg_forward_kinematics.sv =====
// Top level of the three-joint leg forward kinematics pipeline.
//
// Each item carries the mount rotation and the hip, knee and ankle angles in
// degrees with ANGLE_FRAC_BITS fraction bits, and returns the foot position
// x, y, z in millimetres with 4 fraction bits, saturated to 17 bits. The block
// is a single pipeline of CORDIC_STAGES + 8 register stages: one input stage
// that forms the four angle sums, two stages that split each angle into a
// quadrant and a residue, CORDIC_STAGES iterations plus one quadrant stage in
// four parallel CORDIC lanes, and four stages of geometry arithmetic. It takes
// one item per cycle unless a result is held back. rsp_valid rises together
// with the item's result reaching the last geometry stage. When a result is
// held back by rsp_ready, the whole pipeline freezes and req_ready drops;
// nothing is lost or repeated. Geometry registers are written through the
// csr_ port and should only change while no item is in flight.
module leg_forward_kinematics #(
   parameter int ANGLE_FRAC_BITS = 7,
   parameter int CORDIC_STAGES   = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [lfk_pkg::IN_W-1:0]      req_mount_angle,
   input  logic signed [lfk_pkg::IN_W-1:0]      req_hip_joint,
   input  logic signed [lfk_pkg::IN_W-1:0]      req_knee_joint,
   input  logic signed [lfk_pkg::IN_W-1:0]      req_ankle_joint,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [lfk_pkg::OUT_W-1:0]     rsp_foot_x,
   output logic signed [lfk_pkg::OUT_W-1:0]     rsp_foot_y,
   output logic signed [lfk_pkg::OUT_W-1:0]     rsp_foot_z,
   input  logic                                 csr_write_enable,
   input  logic [lfk_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lfk_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   // Angle sums need room for two inputs plus the ankle bias.
   localparam int SUM_W = (((9 + ANGLE_FRAC_BITS) > 18) ? (9 + ANGLE_FRAC_BITS) : 18) + 1;
   localparam int LAT   = CORDIC_STAGES + 8;

   // Configuration registers.
   lfk_pkg::geom_type             geom_ff;
   logic [lfk_pkg::OFF_W-1:0]     ankle_off_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff.radius       <= 10'd188;
         geom_ff.hip_length   <= 10'd80;
         geom_ff.upper_length <= 10'd145;
         geom_ff.lower_length <= 10'd133;
         geom_ff.hip_height   <= 10'sd0;
         ankle_off_ff         <= 8'd90;
      end else if (csr_write_enable) begin
         case (csr_index)
            lfk_pkg::CSR_BODY_PIVOT_RADIUS: geom_ff.radius       <= csr_wdata;
            lfk_pkg::CSR_HIP_LENGTH:        geom_ff.hip_length   <= csr_wdata;
            lfk_pkg::CSR_UPPER_LENGTH:      geom_ff.upper_length <= csr_wdata;
            lfk_pkg::CSR_LOWER_LENGTH:      geom_ff.lower_length <= csr_wdata;
            lfk_pkg::CSR_HIP_HEIGHT:        geom_ff.hip_height   <= $signed(csr_wdata);
            lfk_pkg::CSR_ANKLE_OFFSET:      ankle_off_ff <= csr_wdata[lfk_pkg::OFF_W-1:0];
            default: ;
         endcase
      end
   end

   // The pipeline moves as one: it advances unless the finished result is
   // still waiting for the consumer.
   logic [LAT-1:0] vld_ff;
   logic           advance;

   assign advance   = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // Input stage: the four angles that need sine and cosine.
   logic signed [SUM_W-1:0] rot_ff, head_ff, knee_ff, ankle_ff;
   logic signed [SUM_W-1:0] bias;

   assign bias = $signed(SUM_W'(ankle_off_ff)) <<< ANGLE_FRAC_BITS;

   always_ff @(posedge clock) begin
      if (advance) begin
         rot_ff   <= SUM_W'(req_mount_angle);
         head_ff  <= SUM_W'(req_mount_angle) + SUM_W'(req_hip_joint);
         knee_ff  <= SUM_W'(req_knee_joint);
         ankle_ff <= SUM_W'(req_knee_joint) + SUM_W'(req_ankle_joint) + bias;
      end
   end

   logic signed [SUM_W-1:0]        angles [4];
   logic [1:0]                     quads  [4];
   logic signed [lfk_pkg::ZW-1:0]  resids [4];
   lfk_pkg::trig_type              trigs  [4];

   assign angles[0] = rot_ff;
   assign angles[1] = head_ff;
   assign angles[2] = knee_ff;
   assign angles[3] = ankle_ff;

   for (genvar k = 0; k < 4; k++) begin : g_lane
      lfk_angle_reduce #(
         .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
         .SUM_W(SUM_W)
      ) u_reduce (
         .clock(clock),
         .advance(advance),
         .angle(angles[k]),
         .quadrant(quads[k]),
         .residue(resids[k])
      );

      lfk_cordic #(
         .STAGES(CORDIC_STAGES)
      ) u_cordic (
         .clock(clock),
         .advance(advance),
         .quadrant(quads[k]),
         .angle(resids[k]),
         .result(trigs[k])
      );
   end

   lfk_arm u_arm (
      .clock(clock),
      .advance(advance),
      .geom(geom_ff),
      .mount(trigs[0]),
      .heading(trigs[1]),
      .knee(trigs[2]),
      .ankle(trigs[3]),
      .foot_x(rsp_foot_x),
      .foot_y(rsp_foot_y),
      .foot_z(rsp_foot_z)
   );

   // A waiting result must hold off new items.
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[LAT-1] && !rsp_ready) |-> !req_ready)
      else $error("input accepted while a result is stalled");

   // An accepted item enters the first stage.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("accepted item missing from the first stage");

   // A stalled pipeline keeps every item where it is.
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !req_ready |=> $stable(vld_ff))
      else $error("pipeline moved while stalled");

endmodule
